@@ design/dwsm_pkg.sv @@
// ----------------------------------------------------------------------------
// dwsm_pkg
// Shared types and constants for the dry/wet align and stereo mix core.
// ----------------------------------------------------------------------------
package dwsm_pkg;

    localparam int MAX_DELAY_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int LAT_W      = 10;   // latency registers
    localparam int GAIN_W     = 18;   // Q2.16 gains
    localparam int WIDTH_W    = 17;   // Q1.16 width, 0..1
    localparam int FRAC_W     = 16;   // gain fraction bits
    localparam int OUT_SHIFT  = 17;   // acc scale per output LSB
    localparam int CNT_W      = 32;
    localparam int N_GAIN     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [GAIN_W-1:0] DRY_GAIN_RST = 18'd46341;
    localparam logic [GAIN_W-1:0] WET_GAIN_RST = 18'd65536;
    localparam logic [GAIN_W-1:0] WIDTH_ONE    = 18'd65536;

    // current/target gain slots
    localparam int G_DRY_L = 0;
    localparam int G_DRY_R = 1;
    localparam int G_WET   = 2;
    localparam int G_WIDTH = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRY_LAT   = 3'd0,
        CFG_WET_LAT   = 3'd1,
        CFG_DRY_L_TGT = 3'd2,
        CFG_DRY_R_TGT = 3'd3,
        CFG_WET_TGT   = 3'd4,
        CFG_WIDTH_TGT = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL,
        PH_MIX,
        PH_SUM
    } t_phase;

    typedef struct packed {
        logic mul_en;   // dry products, side product, capture c2
        logic mix_en;   // wet mid/side product
    } t_lane_ctl;

endpackage

@@ design/dwsm_delay.sv @@
// ----------------------------------------------------------------------------
// dwsm_delay
// One alignment delay line: read before write, registered read data.
// ----------------------------------------------------------------------------
module dwsm_delay import dwsm_pkg::*; #(
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_DELAY)-1:0]  i_wr_addr,
    input  logic [$clog2(MAX_DELAY)-1:0]  i_rd_addr,
    input  logic                          i_bypass,
    input  logic                          i_live,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    logic [SAMPLE_BITS-1:0] r_mem [MAX_DELAY];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [SAMPLE_BITS-1:0] r_x;
    logic                   r_bypass;
    logic                   r_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_sample;
            r_rd_data        <= r_mem[i_rd_addr];
            r_x              <= i_sample;
            r_bypass         <= i_bypass;
            r_live           <= i_live;
        end
    end

    // entries not yet written since reset read as zero
    always_comb begin
        if (r_bypass) begin
            o_sample = $signed(r_x);
        end else if (r_live) begin
            o_sample = $signed(r_rd_data);
        end else begin
            o_sample = '0;
        end
    end

endmodule

@@ design/dwsm_lane.sv @@
// ----------------------------------------------------------------------------
// dwsm_lane
// One output channel: dry pan product, wet mid/side product, round, saturate.
// ----------------------------------------------------------------------------
module dwsm_lane import dwsm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  t_lane_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS:0]   i_m2,
    input  logic signed [SAMPLE_BITS:0]   i_c2,
    input  logic signed [SAMPLE_BITS:0]   i_diff,
    input  logic [GAIN_W-1:0]             i_gain_dry,
    input  logic [GAIN_W-1:0]             i_gain_wet,
    input  logic [WIDTH_W-1:0]            i_width,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_sat
);

    localparam int SB     = SAMPLE_BITS;
    localparam int PD_W   = SB + GAIN_W + 2;
    localparam int SIDE_W = SB + WIDTH_W + 2;
    localparam int WS_W   = SIDE_W + 1;
    localparam int W_W    = WS_W - FRAC_W;
    localparam int PW_W   = W_W + GAIN_W + 1;
    localparam int ACC_W  = PW_W + 1;
    localparam int SH_W   = ACC_W - OUT_SHIFT;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (OUT_SHIFT - 1);
    localparam logic signed [SH_W-1:0]  HI  = {{(SH_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SH_W-1:0]  LO  = {{(SH_W-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic signed [PD_W-1:0]   r_pdry;
    logic signed [SIDE_W-1:0] r_side;
    logic signed [SB:0]       r_c2;
    logic signed [PW_W-1:0]   r_pwet;

    logic signed [WS_W-1:0]   c2_sh;
    logic signed [WS_W-1:0]   wsum;
    logic signed [W_W-1:0]    wmix;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SH_W-1:0]   scaled;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_pdry <= i_m2 * $signed({1'b0, i_gain_dry});
            r_side <= i_diff * $signed({1'b0, i_width});
            r_c2   <= i_c2;
        end
        if (i_ctl.mix_en) begin
            r_pwet <= wmix * $signed({1'b0, i_gain_wet});
        end
    end

    // wet channel = floor((c2*2^16 +/- side) / 2^16), sign carried in diff
    always_comb begin
        c2_sh = WS_W'($signed({r_c2, {FRAC_W{1'b0}}}));
        wsum  = c2_sh + WS_W'(r_side);
        wmix  = wsum[WS_W-1:FRAC_W];
    end

    always_comb begin
        acc    = ACC_W'(r_pdry) + ACC_W'(r_pwet) + RND;
        scaled = acc[ACC_W-1:OUT_SHIFT];
        o_sat  = 1'b0;
        if (scaled > HI) begin
            o_sample = HI[SB-1:0];
            o_sat    = 1'b1;
        end else if (scaled < LO) begin
            o_sample = LO[SB-1:0];
            o_sat    = 1'b1;
        end else begin
            o_sample = scaled[SB-1:0];
        end
    end

endmodule

@@ design/dwsm_merge.sv @@
// ----------------------------------------------------------------------------
// dwsm_merge
// Joins both lanes: overflow flag, sticky saturation count, output register.
// ----------------------------------------------------------------------------
module dwsm_merge import dwsm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    input  logic                          i_sat_l,
    input  logic                          i_sat_r,
    output logic                          o_can_load,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [((2*SAMPLE_BITS+CNT_W+7)/8)*8-1:0] o_tdata,
    output logic                          o_tuser
);

    localparam int SB = SAMPLE_BITS;

    logic                 r_valid;
    logic [CNT_W-1:0]     r_count;
    logic [SB-1:0]        r_left;
    logic [SB-1:0]        r_right;
    logic                 r_flag;
    logic                 hit;
    logic [CNT_W-1:0]     n_count;

    assign hit        = i_sat_l | i_sat_r;
    assign o_can_load = !r_valid || i_tready;

    always_comb begin
        n_count = r_count;
        if (hit && (r_count != '1)) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left  <= i_left;
            r_right <= i_right;
            r_flag  <= hit;
        end
    end

    always_comb begin
        o_tdata                 = '0;
        o_tdata[SB-1:0]         = r_left;
        o_tdata[SB +: SB]       = r_right;
        o_tdata[2*SB +: CNT_W]  = r_count;
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_flag;

endmodule

@@ design/dry_wet_align_and_stereo_mix_core.sv @@
// ----------------------------------------------------------------------------
// dry_wet_align_and_stereo_mix_core
// Latency-aligned dry/wet mixer: mono dry with pan gains, mid/side wet.
// ----------------------------------------------------------------------------
//  channel    dir  handshake                 content
//  s_axis     in   tvalid/tready             stereo dry + stereo wet request
//  m_axis     out  tvalid/tready             saturated stereo mix + count
//  cfg        in   i_cfg_we (no back-press)  latencies and gain targets
//
//  Each request runs accept (delay RAM read/write), multiply, wet multiply,
//  round/saturate into the output register before the next is accepted.
//  The output register frees the input side; a stalled m_axis only holds
//  the final phase when a result is still waiting.
//  Reset is synchronous; no RAM clearing pass, a fill count makes unwritten
//  delay entries read as zero.
// ----------------------------------------------------------------------------
module dry_wet_align_and_stereo_mix_core import dwsm_pkg::*; #(
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // dry_left_in, dry_right_in, wet_left_in, wet_right_in
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // smooth_step
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_left, out_right, overflow_total
    output logic [((2*SAMPLE_BITS+CNT_W+7)/8)*8-1:0] o_m_axis_tdata,
    // overflowed
    output logic                  o_m_axis_tuser
);

    localparam int SB       = SAMPLE_BITS;
    localparam int AW       = $clog2(MAX_DELAY);
    localparam int LAST_IDX = MAX_DELAY - 1;

    // ---------------- configuration and gains ----------------
    logic [LAT_W-1:0]  r_dry_lat;
    logic [LAT_W-1:0]  r_wet_lat;
    logic [GAIN_W-1:0] r_tgt  [N_GAIN];
    logic [GAIN_W-1:0] r_gain [N_GAIN];
    logic [GAIN_W-1:0] n_gain [N_GAIN];
    logic [GAIN_W-1:0] width_wr;

    assign width_wr = (i_cfg_data[WIDTH_W-1:0] > WIDTH_ONE[WIDTH_W-1:0]) ?
                      WIDTH_ONE : {1'b0, i_cfg_data[WIDTH_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry_lat        <= '0;
            r_wet_lat        <= '0;
            r_tgt[G_DRY_L]   <= DRY_GAIN_RST;
            r_tgt[G_DRY_R]   <= DRY_GAIN_RST;
            r_tgt[G_WET]     <= WET_GAIN_RST;
            r_tgt[G_WIDTH]   <= WIDTH_ONE;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_DRY_LAT:   r_dry_lat      <= i_cfg_data[LAT_W-1:0];
                CFG_WET_LAT:   r_wet_lat      <= i_cfg_data[LAT_W-1:0];
                CFG_DRY_L_TGT: r_tgt[G_DRY_L] <= i_cfg_data[GAIN_W-1:0];
                CFG_DRY_R_TGT: r_tgt[G_DRY_R] <= i_cfg_data[GAIN_W-1:0];
                CFG_WET_TGT:   r_tgt[G_WET]   <= i_cfg_data[GAIN_W-1:0];
                CFG_WIDTH_TGT: r_tgt[G_WIDTH] <= width_wr;
                default: ;
            endcase
        end
    end

    logic accept;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    // one-eighth step toward target, floor via arithmetic shift
    always_comb begin
        logic signed [GAIN_W:0] diff;
        logic signed [GAIN_W:0] sum;
        for (int i = 0; i < N_GAIN; i++) begin
            diff      = $signed({1'b0, r_tgt[i]}) - $signed({1'b0, r_gain[i]});
            sum       = $signed({1'b0, r_gain[i]}) + (diff >>> 3);
            n_gain[i] = sum[GAIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[G_DRY_L] <= DRY_GAIN_RST;
            r_gain[G_DRY_R] <= DRY_GAIN_RST;
            r_gain[G_WET]   <= WET_GAIN_RST;
            r_gain[G_WIDTH] <= WIDTH_ONE;
        end else if (accept && i_s_axis_tuser) begin
            r_gain <= n_gain;
        end
    end

    // ---------------- alignment ----------------
    function automatic logic [AW-1:0] f_clamp(input logic [LAT_W-1:0] d);
        logic [AW-1:0] res;
        if (32'(d) > 32'(LAST_IDX)) begin
            res = AW'(LAST_IDX);
        end else begin
            res = AW'(d);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] f_rd_addr(input logic [AW-1:0] wp,
                                                  input logic [AW-1:0] d);
        logic [AW:0] s;
        s = {1'b0, wp} + (AW+1)'(MAX_DELAY) - {1'b0, d};
        if (s >= (AW+1)'(MAX_DELAY)) begin
            s = s - (AW+1)'(MAX_DELAY);
        end
        return s[AW-1:0];
    endfunction

    logic [LAT_W-1:0] top_lat;
    logic [AW-1:0]    d_dry;
    logic [AW-1:0]    d_wet;
    logic [AW-1:0]    rd_dry;
    logic [AW-1:0]    rd_wet;
    logic             live_dry;
    logic             live_wet;
    logic [AW-1:0]    r_wp;
    logic [AW:0]      r_fill;

    always_comb begin
        top_lat  = (r_dry_lat > r_wet_lat) ? r_dry_lat : r_wet_lat;
        d_dry    = f_clamp(top_lat - r_dry_lat);
        d_wet    = f_clamp(top_lat - r_wet_lat);
        rd_dry   = f_rd_addr(r_wp, d_dry);
        rd_wet   = f_rd_addr(r_wp, d_wet);
        live_dry = (AW+1)'(d_dry) <= r_fill;
        live_wet = (AW+1)'(d_wet) <= r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (accept) begin
            r_wp <= (r_wp == AW'(LAST_IDX)) ? '0 : r_wp + AW'(1);
            if (r_fill != (AW+1)'(MAX_DELAY)) begin
                r_fill <= r_fill + (AW+1)'(1);
            end
        end
    end

    logic signed [SB-1:0] y_dl, y_dr, y_wl, y_wr;

    dwsm_delay #(.MAX_DELAY(MAX_DELAY), .SAMPLE_BITS(SB)) u_dly_dl (
        .i_clk(i_clk), .i_wr_en(accept), .i_wr_addr(r_wp), .i_rd_addr(rd_dry),
        .i_bypass(d_dry == '0), .i_live(live_dry),
        .i_sample($signed(i_s_axis_tdata[0*SB +: SB])), .o_sample(y_dl)
    );
    dwsm_delay #(.MAX_DELAY(MAX_DELAY), .SAMPLE_BITS(SB)) u_dly_dr (
        .i_clk(i_clk), .i_wr_en(accept), .i_wr_addr(r_wp), .i_rd_addr(rd_dry),
        .i_bypass(d_dry == '0), .i_live(live_dry),
        .i_sample($signed(i_s_axis_tdata[1*SB +: SB])), .o_sample(y_dr)
    );
    dwsm_delay #(.MAX_DELAY(MAX_DELAY), .SAMPLE_BITS(SB)) u_dly_wl (
        .i_clk(i_clk), .i_wr_en(accept), .i_wr_addr(r_wp), .i_rd_addr(rd_wet),
        .i_bypass(d_wet == '0), .i_live(live_wet),
        .i_sample($signed(i_s_axis_tdata[2*SB +: SB])), .o_sample(y_wl)
    );
    dwsm_delay #(.MAX_DELAY(MAX_DELAY), .SAMPLE_BITS(SB)) u_dly_wr (
        .i_clk(i_clk), .i_wr_en(accept), .i_wr_addr(r_wp), .i_rd_addr(rd_wet),
        .i_bypass(d_wet == '0), .i_live(live_wet),
        .i_sample($signed(i_s_axis_tdata[3*SB +: SB])), .o_sample(y_wr)
    );

    // ---------------- sequencer ----------------
    t_phase    r_phase;
    t_phase    n_phase;
    t_lane_ctl lane_ctl;
    logic      can_load;
    logic      load;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: if (i_s_axis_tvalid) n_phase = PH_MUL;
            PH_MUL:  n_phase = PH_MIX;
            PH_MIX:  n_phase = PH_SUM;
            PH_SUM:  if (can_load) n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        lane_ctl        = '0;
        load            = 1'b0;
        case (r_phase)
            PH_IDLE: o_s_axis_tready = 1'b1;
            PH_MUL:  lane_ctl.mul_en = 1'b1;
            PH_MIX:  lane_ctl.mix_en = 1'b1;
            PH_SUM:  load            = can_load;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // ---------------- lanes ----------------
    logic signed [SB:0] m2, c2, diff_l, diff_r;

    always_comb begin
        m2     = {y_dl[SB-1], y_dl} + {y_dr[SB-1], y_dr};
        c2     = {y_wl[SB-1], y_wl} + {y_wr[SB-1], y_wr};
        diff_l = {y_wl[SB-1], y_wl} - {y_wr[SB-1], y_wr};
        diff_r = {y_wr[SB-1], y_wr} - {y_wl[SB-1], y_wl};
    end

    logic signed [SB-1:0] mix_l, mix_r;
    logic                 sat_l, sat_r;

    dwsm_lane #(.SAMPLE_BITS(SB)) u_lane_l (
        .i_clk(i_clk), .i_ctl(lane_ctl), .i_m2(m2), .i_c2(c2), .i_diff(diff_l),
        .i_gain_dry(r_gain[G_DRY_L]), .i_gain_wet(r_gain[G_WET]),
        .i_width(r_gain[G_WIDTH][WIDTH_W-1:0]), .o_sample(mix_l), .o_sat(sat_l)
    );
    dwsm_lane #(.SAMPLE_BITS(SB)) u_lane_r (
        .i_clk(i_clk), .i_ctl(lane_ctl), .i_m2(m2), .i_c2(c2), .i_diff(diff_r),
        .i_gain_dry(r_gain[G_DRY_R]), .i_gain_wet(r_gain[G_WET]),
        .i_width(r_gain[G_WIDTH][WIDTH_W-1:0]), .o_sample(mix_r), .o_sat(sat_r)
    );

    dwsm_merge #(.SAMPLE_BITS(SB)) u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load),
        .i_left(mix_l), .i_right(mix_r), .i_sat_l(sat_l), .i_sat_r(sat_r),
        .o_can_load(can_load), .o_tvalid(o_m_axis_tvalid), .i_tready(i_m_axis_tready),
        .o_tdata(o_m_axis_tdata), .o_tuser(o_m_axis_tuser)
    );

endmodule
